>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition implies a consequence in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/tcd_pkg.sv
// shared types, constants and functions of the tile cache directory
`default_nettype none
package tcd_pkg;

  localparam int TileSlotsDef = 128;
  localparam int ReqSlotsDef  = 64;

  localparam int OpW      = 4;
  localparam int ZoomW    = 5;
  localparam int CoordW   = 31;
  localparam int SlotW    = 7;
  localparam int EvW      = 4;
  localparam int CsW      = 7;
  localparam int TickW    = 32;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 32;

  localparam logic [CsW-1:0]   CacheSizeReset = CsW'(100);
  localparam logic [TickW-1:0] LifetimeReset  = TickW'(5 * 60 * 1000);

  // cache_size / 10 as multiply by 205 and shift by 11, exact below 1029
  localparam int EvictDiv   = 10;
  localparam int DivShift   = 11;
  localparam int DivRecip   = ((1 << DivShift) + EvictDiv - 1) / EvictDiv;
  localparam int DivProdW   = CsW + 8;

  localparam logic [CfgIdxW-1:0] CFG_CACHE_SIZE = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_LIFETIME   = CfgIdxW'(1);

  typedef enum logic [OpW-1:0] {
    OP_TICK      = 4'd0,
    OP_REQUEST   = 4'd1,
    OP_CLAIM     = 4'd2,
    OP_TEST_REQ  = 4'd3,
    OP_TEST_TILE = 4'd4,
    OP_GET       = 4'd5,
    OP_REMOVE    = 4'd6,
    OP_PUT       = 4'd7,
    OP_CLEAR     = 4'd8
  } tcd_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_R_RD,
    ST_R_CMP,
    ST_R_ACT,
    ST_T_RD,
    ST_T_CMP,
    ST_T_ACT,
    ST_EV_RD,
    ST_EV_CMP,
    ST_EV_FIN,
    ST_DONE
  } tcd_state_e;

  typedef struct packed {
    logic [ZoomW-1:0]  zoom;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
  } key_t;

  typedef struct packed {
    key_t             key;
    logic [TickW-1:0] stamp;
  } tile_word_t;

  typedef struct packed {
    logic [TickW-1:0] age;
    logic             older;
    logic             expired;
  } age_res_t;

  function automatic logic [EvW-1:0] evict_limit(logic [CsW-1:0] cs);
    logic [DivProdW-1:0] prod;
    prod = DivProdW'(cs) * DivProdW'(DivRecip);
    return EvW'(prod >> DivShift);
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tcd_in_if.sv
// operation channel of the tile cache directory
`default_nettype none
interface tcd_in_if;
  import tcd_pkg::*;
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    opcode;
  logic [ZoomW-1:0]  zoom;
  logic [CoordW-1:0] tile_x;
  logic [CoordW-1:0] tile_y;
  modport source (output valid, opcode, zoom, tile_x, tile_y, input ready);
  modport sink   (input valid, opcode, zoom, tile_x, tile_y, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tcd_out_if.sv
// result channel of the tile cache directory
`default_nettype none
interface tcd_out_if;
  import tcd_pkg::*;
  logic             valid;
  logic             ready;
  logic             answer;
  logic [SlotW-1:0] slot;
  logic [EvW-1:0]   evicted_count;
  logic             status;
  modport source (output valid, answer, slot, evicted_count, status, input ready);
  modport sink   (input valid, answer, slot, evicted_count, status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tcd_store.sv
// table memory with one write port and one registered read port
`default_nettype none
module tcd_store #(
  parameter int Depth = 64,
  parameter int Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

>>> hw/rtl/tcd_age.sv
// shared age subtractor and comparators
`default_nettype none
module tcd_age (
  input  wire logic [tcd_pkg::TickW-1:0] now_i,
  input  wire logic [tcd_pkg::TickW-1:0] stamp_i,
  input  wire logic [tcd_pkg::TickW-1:0] best_i,
  input  wire logic [tcd_pkg::TickW-1:0] life_i,
  output tcd_pkg::age_res_t              res_o
);
  import tcd_pkg::*;
  logic [TickW-1:0] age;

  assign age           = now_i - stamp_i;
  assign res_o.age     = age;
  assign res_o.older   = age > best_i;
  assign res_o.expired = age > life_i;
endmodule
`default_nettype wire

>>> hw/rtl/tile_cache_directory_with_age_eviction.sv
// Tile cache directory: a tile table and a request table, both keyed by zoom, column and row,
// held in memories with a write port and a registered read port and searched linearly, one
// entry at a time in a read state, then a compare state (tiles via the shared age unit). Tick,
// clear pending and unknown opcodes go straight to the done state; request operations scan the
// request table; test tile and get the tile table; put both, then a possible eviction pass.
// One operation is in flight at a time; in_ch.ready is high only while the sequencer is idle.
// Valid bits sit in flip-flops and clear at reset, so there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module tile_cache_directory_with_age_eviction #(
  parameter int TILE_SLOTS    = tcd_pkg::TileSlotsDef,
  parameter int REQUEST_SLOTS = tcd_pkg::ReqSlotsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  tcd_in_if.sink                             in_ch,
  tcd_out_if.source                          out_ch,
  input  wire logic                          cfg_we_i,
  input  wire logic [tcd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [tcd_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tcd_pkg::*;

  localparam int TW = $clog2(TILE_SLOTS);
  localparam int RW = $clog2(REQUEST_SLOTS);
  localparam int CW = $clog2(TILE_SLOTS + 1);
  localparam logic [TW-1:0] TLast = TW'(TILE_SLOTS - 1);
  localparam logic [RW-1:0] RLast = RW'(REQUEST_SLOTS - 1);

  tcd_state_e state_q, state_d;

  logic [OpW-1:0]  op_q, op_d;
  key_t            key_q, key_d;
  logic [TW-1:0]   tidx_q, tidx_d;
  logic [RW-1:0]   ridx_q, ridx_d;
  logic            rhit_q, rhit_d, rfree_q, rfree_d;
  logic [RW-1:0]   rhit_idx_q, rhit_idx_d, rfree_idx_q, rfree_idx_d;
  logic            thit_q, thit_d, tfree_q, tfree_d;
  logic [TW-1:0]   thit_idx_q, thit_idx_d, tfree_idx_q, tfree_idx_d;
  logic [TickW-1:0] best_q, best_d;
  logic [TW-1:0]   best_idx_q, best_idx_d;
  logic [TW-1:0]   slot_q, slot_d;
  logic [EvW-1:0]  removed_q, removed_d, limit_q, limit_d;
  logic            ans_q, ans_d, stat_q, stat_d;

  logic [TickW-1:0] now_q, now_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CsW-1:0]   cs_q;
  logic [TickW-1:0] life_q;
  logic [TILE_SLOTS-1:0]    tvalid_q, tvalid_d;
  logic [REQUEST_SLOTS-1:0] rvalid_q, rvalid_d, rpend_q, rpend_d;

  logic             ovalid_q, ovalid_d;
  logic             oans_q, oans_d, ostat_q, ostat_d;
  logic [SlotW-1:0] oslot_q, oslot_d;
  logic [EvW-1:0]   oev_q, oev_d;

  logic       t_we, r_we;
  logic [TW-1:0] t_waddr;
  logic [RW-1:0] r_waddr;
  tile_word_t t_wdata, t_rdata;
  key_t       r_wdata, r_rdata;
  age_res_t   age;

  logic          in_xfer, out_xfer;
  logic          put_grow;
  logic [CW-1:0] put_count;
  logic          put_over;
  logic [EvW-1:0] lim;
  logic [TW-1:0] put_slot;
  logic          ev_rm;

  tcd_store #(.Depth(TILE_SLOTS), .Width($bits(tile_word_t))) u_tiles (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (tidx_q),
    .rdata_o (t_rdata)
  );

  tcd_store #(.Depth(REQUEST_SLOTS), .Width($bits(key_t))) u_reqs (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (ridx_q),
    .rdata_o (r_rdata)
  );

  tcd_age u_age (
    .now_i   (now_q),
    .stamp_i (t_rdata.stamp),
    .best_i  (best_q),
    .life_i  (life_q),
    .res_o   (age)
  );

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = ovalid_q && out_ch.ready;

  assign out_ch.valid         = ovalid_q;
  assign out_ch.answer        = oans_q;
  assign out_ch.slot          = oslot_q;
  assign out_ch.evicted_count = oev_q;
  assign out_ch.status        = ostat_q;

  assign put_grow  = !thit_q && tfree_q;
  assign put_count = count_q + CW'(put_grow);
  assign put_over  = 32'(put_count) > 32'(cs_q);
  assign lim       = evict_limit(cs_q);
  assign put_slot  = thit_q ? thit_idx_q : (tfree_q ? tfree_idx_q : best_idx_q);
  assign ev_rm     = tvalid_q[tidx_q] && age.expired;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_ch.opcode)
            OP_REQUEST, OP_CLAIM, OP_TEST_REQ, OP_REMOVE, OP_PUT: state_d = ST_R_RD;
            OP_TEST_TILE, OP_GET:                                 state_d = ST_T_RD;
            default:                                              state_d = ST_DONE;
          endcase
        end
      end
      ST_R_RD:  state_d = ST_R_CMP;
      ST_R_CMP: state_d = (ridx_q == RLast) ? ST_R_ACT : ST_R_RD;
      ST_R_ACT: state_d = (op_q == OP_PUT) ? ST_T_RD : ST_DONE;
      ST_T_RD:  state_d = ST_T_CMP;
      ST_T_CMP: state_d = (tidx_q == TLast) ? ST_T_ACT : ST_T_RD;
      ST_T_ACT: begin
        if (op_q == OP_PUT && put_over) begin
          state_d = (lim == '0) ? ST_EV_FIN : ST_EV_RD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_EV_RD: state_d = ST_EV_CMP;
      ST_EV_CMP: begin
        if (tidx_q == TLast || (removed_q + EvW'(ev_rm)) >= limit_q) begin
          state_d = ST_EV_FIN;
        end else begin
          state_d = ST_EV_RD;
        end
      end
      ST_EV_FIN: state_d = ST_DONE;
      ST_DONE:   state_d = (!ovalid_q || out_ch.ready) ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    tidx_d      = tidx_q;
    ridx_d      = ridx_q;
    rhit_d      = rhit_q;
    rhit_idx_d  = rhit_idx_q;
    rfree_d     = rfree_q;
    rfree_idx_d = rfree_idx_q;
    thit_d      = thit_q;
    thit_idx_d  = thit_idx_q;
    tfree_d     = tfree_q;
    tfree_idx_d = tfree_idx_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    slot_d      = slot_q;
    removed_d   = removed_q;
    limit_d     = limit_q;
    ans_d       = ans_q;
    stat_d      = stat_q;
    now_d       = now_q;
    count_d     = count_q;
    tvalid_d    = tvalid_q;
    rvalid_d    = rvalid_q;
    rpend_d     = rpend_q;
    ovalid_d    = out_xfer ? 1'b0 : ovalid_q;
    oans_d      = oans_q;
    oslot_d     = oslot_q;
    oev_d       = oev_q;
    ostat_d     = ostat_q;
    t_we        = 1'b0;
    t_waddr     = put_slot;
    t_wdata     = '{key: key_q, stamp: now_q};
    r_we        = 1'b0;
    r_waddr     = rfree_idx_q;
    r_wdata     = key_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d       = in_ch.opcode;
          key_d      = '{zoom: in_ch.zoom, col: in_ch.tile_x, row: in_ch.tile_y};
          ridx_d     = '0;
          tidx_d     = '0;
          rhit_d     = 1'b0;
          rfree_d    = 1'b0;
          thit_d     = 1'b0;
          tfree_d    = 1'b0;
          best_d     = '0;
          best_idx_d = '0;
          ans_d      = 1'b0;
          stat_d     = 1'b0;
          slot_d     = '0;
          removed_d  = '0;
          if (in_ch.opcode == OP_TICK) begin
            now_d = now_q + 1'b1;
          end
          if (in_ch.opcode == OP_CLEAR) begin
            rvalid_d = rvalid_q & ~rpend_q;
            rpend_d  = '0;
          end
        end
      end
      ST_R_CMP: begin
        if (rvalid_q[ridx_q] && r_rdata == key_q && !rhit_q) begin
          rhit_d     = 1'b1;
          rhit_idx_d = ridx_q;
        end
        if (!rvalid_q[ridx_q] && !rfree_q) begin
          rfree_d     = 1'b1;
          rfree_idx_d = ridx_q;
        end
        ridx_d = ridx_q + 1'b1;
      end
      ST_R_ACT: begin
        case (op_q)
          OP_REQUEST: begin
            if (!rhit_q) begin
              if (rfree_q) begin
                r_we                  = 1'b1;
                rvalid_d[rfree_idx_q] = 1'b1;
                rpend_d[rfree_idx_q]  = 1'b1;
                ans_d                 = 1'b1;
              end else begin
                stat_d = 1'b1;
              end
            end
          end
          OP_CLAIM: begin
            if (rhit_q && rpend_q[rhit_idx_q]) begin
              rpend_d[rhit_idx_q] = 1'b0;
              ans_d               = 1'b1;
            end
          end
          OP_TEST_REQ: ans_d = rhit_q;
          OP_REMOVE, OP_PUT: begin
            if (rhit_q) begin
              rvalid_d[rhit_idx_q] = 1'b0;
              rpend_d[rhit_idx_q]  = 1'b0;
            end
          end
          default: ;
        endcase
      end
      ST_T_CMP: begin
        if (tvalid_q[tidx_q] && t_rdata.key == key_q && !thit_q) begin
          thit_d     = 1'b1;
          thit_idx_d = tidx_q;
        end
        if (!tvalid_q[tidx_q] && !tfree_q) begin
          tfree_d     = 1'b1;
          tfree_idx_d = tidx_q;
        end
        if (tvalid_q[tidx_q] && age.older) begin
          best_d     = age.age;
          best_idx_d = tidx_q;
        end
        tidx_d = tidx_q + 1'b1;
      end
      ST_T_ACT: begin
        case (op_q)
          OP_TEST_TILE: ans_d = thit_q;
          OP_GET: begin
            if (thit_q) begin
              t_we    = 1'b1;
              t_waddr = thit_idx_q;
              ans_d   = 1'b1;
              slot_d  = thit_idx_q;
            end
          end
          OP_PUT: begin
            t_we   = 1'b1;
            slot_d = put_slot;
            if (put_grow) begin
              tvalid_d[put_slot] = 1'b1;
            end
            count_d = put_count;
            if (put_over) begin
              limit_d    = lim;
              tidx_d     = '0;
              best_d     = '0;
              best_idx_d = put_slot;
              removed_d  = '0;
            end
          end
          default: ;
        endcase
      end
      ST_EV_CMP: begin
        if (tvalid_q[tidx_q]) begin
          if (age.older) begin
            best_d     = age.age;
            best_idx_d = tidx_q;
          end
          if (age.expired) begin
            tvalid_d[tidx_q] = 1'b0;
            count_d          = count_q - 1'b1;
            removed_d        = removed_q + 1'b1;
          end
        end
        tidx_d = tidx_q + 1'b1;
      end
      ST_EV_FIN: begin
        if (removed_q == '0 && tvalid_q[best_idx_q]) begin
          tvalid_d[best_idx_q] = 1'b0;
          count_d              = count_q - 1'b1;
          removed_d            = EvW'(1);
        end
      end
      ST_DONE: begin
        if (!ovalid_q || out_ch.ready) begin
          ovalid_d = 1'b1;
          oans_d   = ans_q;
          oslot_d  = SlotW'(slot_q);
          oev_d    = removed_q;
          ostat_d  = stat_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      now_q    <= '0;
      count_q  <= '0;
      tvalid_q <= '0;
      rvalid_q <= '0;
      rpend_q  <= '0;
      cs_q     <= CacheSizeReset;
      life_q   <= LifetimeReset;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      now_q    <= now_d;
      count_q  <= count_d;
      tvalid_q <= tvalid_d;
      rvalid_q <= rvalid_d;
      rpend_q  <= rpend_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CACHE_SIZE: cs_q   <= cfg_data_i[CsW-1:0];
          CFG_LIFETIME:   life_q <= cfg_data_i[TickW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    tidx_q      <= tidx_d;
    ridx_q      <= ridx_d;
    rhit_q      <= rhit_d;
    rhit_idx_q  <= rhit_idx_d;
    rfree_q     <= rfree_d;
    rfree_idx_q <= rfree_idx_d;
    thit_q      <= thit_d;
    thit_idx_q  <= thit_idx_d;
    tfree_q     <= tfree_d;
    tfree_idx_q <= tfree_idx_d;
    best_q      <= best_d;
    best_idx_q  <= best_idx_d;
    slot_q      <= slot_d;
    removed_q   <= removed_d;
    limit_q     <= limit_d;
    ans_q       <= ans_d;
    stat_q      <= stat_d;
    oans_q      <= oans_d;
    oslot_q     <= oslot_d;
    oev_q       <= oev_d;
    ostat_q     <= ostat_d;
  end

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, 32'(count_q) <= TILE_SLOTS, "tile count overflow")
  `ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_xfer, state_q != ST_IDLE, "accepted but idle")
  `ASSERT_ALWAYS(a_ev_limit, clk_i, rst_ni,
    !(state_q == ST_EV_RD || state_q == ST_EV_CMP) || (removed_q < limit_q),
    "eviction past limit")

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// self-checking testbench of the tile cache directory with age based eviction
module tb_top;
  import tcd_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  tcd_in_if in_ch ();
  tcd_out_if out_ch ();

  tile_cache_directory_with_age_eviction dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  localparam int NTile = 128;
  localparam int NReq = 64;
  localparam longint CycleLimit = 10000000;

  typedef struct packed {
    logic answer;
    logic [SlotW-1:0] slot;
    logic [EvW-1:0] evicted_count;
    logic status;
  } dir_result_t;

  typedef struct packed {
    logic [OpW-1:0] opcode;
    logic [ZoomW-1:0] zoom;
    logic [CoordW-1:0] tile_x;
    logic [CoordW-1:0] tile_y;
    logic known;
    dir_result_t res;
  } dir_row_t;

  // predictor state
  logic [CsW-1:0] m_cache_size;
  logic [TickW-1:0] m_lifetime;
  logic m_tv[NTile];
  key_t m_tkey[NTile];
  logic [TickW-1:0] m_tstamp[NTile];
  logic m_rv[NReq];
  logic m_rp[NReq];
  key_t m_rkey[NReq];
  logic [TickW-1:0] m_now;
  int m_count;

  dir_result_t pending_results[$];
  dir_result_t typed_results[$];
  logic typed_flag[$];
  int errors;
  longint cycles = 0;
  int hold_cycles = 0;
  bit no_idle;
  bit long_hold;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input dir_result_t got,
                                 input dir_result_t want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic int find_tile(key_t k);
    for (int i = 0; i < NTile; i++)
      if (m_tv[i] && m_tkey[i] == k) return i;
    return -1;
  endfunction

  function automatic int find_req(key_t k);
    for (int i = 0; i < NReq; i++)
      if (m_rv[i] && m_rkey[i] == k) return i;
    return -1;
  endfunction

  function automatic dir_result_t predict_directory(logic [OpW-1:0] op, key_t k);
    dir_result_t r;
    int s;
    int oldest_slot;
    logic [TickW-1:0] age;
    logic [TickW-1:0] best;
    int removed;
    int lim;
    r = '0;
    case (op)
      OP_TICK: m_now = m_now + 1;
      OP_REQUEST: begin
        if (find_req(k) < 0) begin
          s = -1;
          for (int i = 0; i < NReq; i++)
            if (!m_rv[i] && s < 0) s = i;
          if (s < 0) r.status = 1'b1;
          else begin
            m_rv[s] = 1'b1; m_rp[s] = 1'b1; m_rkey[s] = k; r.answer = 1'b1;
          end
        end
      end
      OP_CLAIM: begin
        s = find_req(k);
        if (s >= 0 && m_rp[s]) begin m_rp[s] = 1'b0; r.answer = 1'b1; end
      end
      OP_TEST_REQ: r.answer = find_req(k) >= 0;
      OP_TEST_TILE: r.answer = find_tile(k) >= 0;
      OP_GET: begin
        s = find_tile(k);
        if (s >= 0) begin m_tstamp[s] = m_now; r.answer = 1'b1; r.slot = SlotW'(s); end
      end
      OP_REMOVE: begin
        s = find_req(k);
        if (s >= 0) begin m_rv[s] = 1'b0; m_rp[s] = 1'b0; end
      end
      OP_PUT: begin
        s = find_req(k);
        if (s >= 0) begin m_rv[s] = 1'b0; m_rp[s] = 1'b0; end
        s = find_tile(k);
        if (s < 0) begin
          for (int i = 0; i < NTile; i++)
            if (!m_tv[i] && s < 0) s = i;
          if (s < 0) begin
            best = '0; s = 0;
            for (int i = 0; i < NTile; i++) begin
              age = m_now - m_tstamp[i];
              if (age > best) begin best = age; s = i; end
            end
          end else begin
            m_tv[s] = 1'b1; m_count++;
          end
          m_tkey[s] = k;
        end
        m_tstamp[s] = m_now;
        r.slot = SlotW'(s);
        if (m_count > m_cache_size) begin
          lim = m_cache_size / 10;
          removed = 0; best = '0; oldest_slot = s;
          for (int i = 0; i < NTile && removed < lim; i++) begin
            if (m_tv[i]) begin
              age = m_now - m_tstamp[i];
              if (age > best) begin best = age; oldest_slot = i; end
              if (age > m_lifetime) begin m_tv[i] = 1'b0; m_count--; removed++; end
            end
          end
          if (removed == 0 && m_tv[oldest_slot]) begin
            m_tv[oldest_slot] = 1'b0; m_count--; removed = 1;
          end
          r.evicted_count = EvW'(removed);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < NReq; i++)
          if (m_rv[i] && m_rp[i]) begin m_rv[i] = 1'b0; m_rp[i] = 1'b0; end
      end
      default: ;
    endcase
    return r;
  endfunction

  // one operation transfer, optionally with a typed expectation
  task automatic send_op(logic [OpW-1:0] op, key_t k, bit known, dir_result_t want);
    dir_result_t p;
    while (!no_idle && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.zoom <= k.zoom;
    in_ch.tile_x <= k.col;
    in_ch.tile_y <= k.row;
    do @(posedge clk_i); while (!in_ch.ready);
    p = predict_directory(op, k);
    pending_results.push_back(p);
    typed_results.push_back(want);
    typed_flag.push_back(known);
  endtask

  always @(posedge clk_i) begin
    dir_result_t got;
    dir_result_t want;
    if (out_ch.valid && out_ch.ready) begin
      got = '{out_ch.answer, out_ch.slot, out_ch.evicted_count, out_ch.status};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer", got, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.answer !== want.answer) report_mismatch("answer", got, want);
        if (got.slot !== want.slot) report_mismatch("slot", got, want);
        if (got.evicted_count !== want.evicted_count) report_mismatch("evicted", got, want);
        if (got.status !== want.status) report_mismatch("status", got, want);
        if (typed_flag.pop_front()) begin
          want = typed_results.pop_front();
          if (got !== want) report_mismatch("table", got, want);
        end else begin
          void'(typed_results.pop_front());
        end
      end
    end
  end

  // receiver side stalls
  always @(posedge clk_i) begin
    if (!long_hold) hold_cycles <= 0;
    else if (hold_cycles < 2000) hold_cycles <= hold_cycles + 1;
    if (!rst_ni) out_ch.ready <= 1'b0;
    else if (long_hold && hold_cycles < 2000) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 9);
  end

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CACHE_SIZE) m_cache_size = val[CsW-1:0];
    else m_lifetime = val;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (800) @(posedge clk_i);
  endtask

  function automatic key_t rand_key(int pool);
    key_t k;
    if (pool == 0) begin
      k.zoom = ZoomW'($urandom);
      k.col = CoordW'($urandom);
      k.row = CoordW'($urandom);
    end else begin
      k.zoom = ZoomW'($urandom_range(1));
      k.col = CoordW'($urandom_range(pool - 1));
      k.row = ($urandom_range(7) == 0) ? {CoordW{1'b1}} : CoordW'($urandom_range(3));
    end
    return k;
  endfunction

  dir_row_t stim_table[] = '{
    '{OP_TEST_TILE, 5'd0, 31'd0, 31'd0, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{OP_GET, 5'd31, 31'h7fffffff, 31'h7fffffff, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{OP_REQUEST, 5'd31, 31'h7fffffff, 31'h7fffffff, 1'b1, '{1'b1, 7'd0, 4'd0, 1'b0}},
    '{OP_REQUEST, 5'd31, 31'h7fffffff, 31'h7fffffff, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{OP_TEST_REQ, 5'd31, 31'h7fffffff, 31'h7fffffff, 1'b1, '{1'b1, 7'd0, 4'd0, 1'b0}},
    '{OP_CLAIM, 5'd31, 31'h7fffffff, 31'h7fffffff, 1'b1, '{1'b1, 7'd0, 4'd0, 1'b0}},
    '{OP_CLAIM, 5'd31, 31'h7fffffff, 31'h7fffffff, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{OP_CLAIM, 5'd0, 31'd0, 31'd0, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{OP_REQUEST, 5'd0, 31'd0, 31'd0, 1'b1, '{1'b1, 7'd0, 4'd0, 1'b0}},
    '{OP_CLEAR, 5'd0, 31'd0, 31'd0, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{OP_TEST_REQ, 5'd0, 31'd0, 31'd0, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{OP_TEST_REQ, 5'd31, 31'h7fffffff, 31'h7fffffff, 1'b1, '{1'b1, 7'd0, 4'd0, 1'b0}},
    '{OP_PUT, 5'd31, 31'h7fffffff, 31'h7fffffff, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{OP_TEST_REQ, 5'd31, 31'h7fffffff, 31'h7fffffff, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{OP_PUT, 5'd0, 31'd0, 31'd0, 1'b1, '{1'b0, 7'd1, 4'd0, 1'b0}},
    '{OP_TICK, 5'd0, 31'd0, 31'd0, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{OP_GET, 5'd0, 31'd0, 31'd0, 1'b1, '{1'b1, 7'd1, 4'd0, 1'b0}},
    '{OP_PUT, 5'd31, 31'h7fffffff, 31'h7fffffff, 1'b0, '0},
    '{OP_REQUEST, 5'd3, 31'd5, 31'd6, 1'b0, '0},
    '{OP_REMOVE, 5'd3, 31'd5, 31'd6, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{OP_REMOVE, 5'd3, 31'd5, 31'd6, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{4'd9, 5'd1, 31'd1, 31'd1, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{4'd15, 5'd31, 31'h7fffffff, 31'h7fffffff, 1'b1, '{1'b0, 7'd0, 4'd0, 1'b0}},
    '{OP_TEST_TILE, 5'd0, 31'd0, 31'd0, 1'b1, '{1'b1, 7'd0, 4'd0, 1'b0}}
  };

  initial begin
    key_t k;
    int pool;
    int cs;
    logic [OpW-1:0] op;
    errors = 0; no_idle = 1'b0; long_hold = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_ch.valid = 1'b0; in_ch.opcode = '0; in_ch.zoom = '0;
    in_ch.tile_x = '0; in_ch.tile_y = '0;
    m_cache_size = CacheSizeReset; m_lifetime = LifetimeReset;
    m_now = '0; m_count = 0;
    for (int i = 0; i < NTile; i++) begin m_tv[i] = 0; m_tkey[i] = '0; m_tstamp[i] = '0; end
    for (int i = 0; i < NReq; i++) begin m_rv[i] = 0; m_rp[i] = 0; m_rkey[i] = '0; end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i])
      send_op(stim_table[i].opcode, '{stim_table[i].zoom, stim_table[i].tile_x,
              stim_table[i].tile_y}, stim_table[i].known, stim_table[i].res);
    drain();

    // phases of random traffic over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_cfg(CFG_CACHE_SIZE, 10); write_cfg(CFG_LIFETIME, 0); end
        1: begin write_cfg(CFG_CACHE_SIZE, 127); write_cfg(CFG_LIFETIME, 32'hffffffff); end
        2: begin write_cfg(CFG_CACHE_SIZE, 20); write_cfg(CFG_LIFETIME, 5); end
        3: begin write_cfg(CFG_CACHE_SIZE, 3); write_cfg(CFG_LIFETIME, 2); end
        4: begin write_cfg(CFG_CACHE_SIZE, 127); write_cfg(CFG_LIFETIME, 30); end
        5: begin
          cs = $urandom_range(10, 127);
          write_cfg(CFG_CACHE_SIZE, cs); write_cfg(CFG_LIFETIME, $urandom_range(20));
        end
        6: write_cfg(CFG_CACHE_SIZE, 32'hffffff80 | 32'd64);
        default: write_cfg(CFG_LIFETIME, $urandom);
      endcase
      no_idle = (ph == 2);
      if (ph == 3) long_hold = 1'b1;
      pool = (ph == 1 || ph == 4) ? 80 : 24;
      for (int n = 0; n < 200; n++) begin
        op = OpW'($urandom_range(8));
        if ($urandom_range(99) < 15) op = OP_PUT;
        if ($urandom_range(99) < 3) op = OpW'($urandom_range(15, 9));
        k = rand_key(($urandom_range(19) == 0) ? 0 : pool);
        send_op(op, k, 1'b0, '0);
      end
      long_hold = 1'b0;
      drain();
    end

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
